[design/qvr_pkg.sv]
// Package: beat types, fixed-point constants and pipeline depths for the quaternion rotator.
`timescale 1ns / 1ps
package qvr_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;
    localparam int NORM_GUARD = 16;

    // square root of s * 2^(2*NORM_GUARD), one round per stage
    localparam int SQRT_STEPS = 32;
    localparam int RAD_W      = 64;
    localparam int LEN_W      = 32;

    // unit-vector divide: quotient is at most 2^FRAC_BITS
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_W      = 16 + FRAC_BITS + NORM_GUARD;

    // Hamilton product widths
    localparam int P1_W = 32;
    localparam int S1_W = P1_W + 2;
    localparam int T_W  = S1_W - FRAC_BITS;
    localparam int P2_W = 16 + T_W;
    localparam int S2_W = P2_W + 2;
    localparam int R_W  = S2_W - FRAC_BITS;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] rot_x;
        logic signed [COMP_WIDTH-1:0] rot_y;
        logic signed [COMP_WIDTH-1:0] rot_z;
        logic                         zero_vector;
        logic                         saturated;
    } t_out_beat;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_unit;

endpackage

[design/qvr_isqrt.sv]
// Squared length and pipelined bitwise square root of the scaled squared length.
`timescale 1ns / 1ps
module qvr_isqrt
    import qvr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_in_beat            i_beat,
    output logic                o_valid,
    output t_in_beat            o_beat,
    output logic [LEN_W-1:0]    o_len
);

    logic                r_v    [0:SQRT_STEPS];
    logic [RAD_W-1:0]    r_x    [0:SQRT_STEPS];
    logic [RAD_W-1:0]    r_root [0:SQRT_STEPS];
    t_in_beat            r_beat [0:SQRT_STEPS];
    logic signed [31:0]  w_sq_x, w_sq_y, w_sq_z;
    logic [31:0]         w_sum;

    // sum of squares, below 2^32
    always_comb begin
        w_sq_x = i_beat.vec_x * i_beat.vec_x;
        w_sq_y = i_beat.vec_y * i_beat.vec_y;
        w_sq_z = i_beat.vec_z * i_beat.vec_z;
        w_sum  = 32'(unsigned'(w_sq_x)) + 32'(unsigned'(w_sq_y)) + 32'(unsigned'(w_sq_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= RAD_W'(w_sum) << (2 * NORM_GUARD);
        r_root[0] <= '0;
        r_beat[0] <= i_beat;
    end

    // one root bit per stage
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        localparam logic [RAD_W-1:0] STEP_BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
        logic [RAD_W-1:0] w_trial;
        assign w_trial = r_root[i] + STEP_BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_beat[i+1] <= r_beat[i];
            if (r_x[i] >= w_trial) begin
                r_x[i+1]    <= r_x[i] - w_trial;
                r_root[i+1] <= (r_root[i] >> 1) + STEP_BIT;
            end else begin
                r_x[i+1]    <= r_x[i];
                r_root[i+1] <= r_root[i] >> 1;
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS];
    assign o_beat  = r_beat[SQRT_STEPS];
    assign o_len   = r_root[SQRT_STEPS][LEN_W-1:0];

endmodule

[design/qvr_div.sv]
// Pipelined restoring divide that scales the vector to unit length.
`timescale 1ns / 1ps
module qvr_div
    import qvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in_beat          i_beat,
    input  logic [LEN_W-1:0]  i_len,
    output logic              o_valid,
    output t_in_beat          o_beat,
    output t_unit             o_unit
);

    logic              r_v    [0:QUO_W];
    t_in_beat          r_beat [0:QUO_W];
    logic [LEN_W-1:0]  r_len  [0:QUO_W];
    logic [DIV_W-1:0]  r_rem  [0:QUO_W][0:2];
    logic [QUO_W-1:0]  r_quo  [0:QUO_W][0:2];
    logic [15:0]       w_mag  [0:2];
    logic signed [15:0] w_n   [0:2];

    // magnitudes; the most negative input reads correctly as unsigned
    always_comb begin
        w_mag[0] = i_beat.vec_x[15] ? 16'(-i_beat.vec_x) : 16'(i_beat.vec_x);
        w_mag[1] = i_beat.vec_y[15] ? 16'(-i_beat.vec_y) : 16'(i_beat.vec_y);
        w_mag[2] = i_beat.vec_z[15] ? 16'(-i_beat.vec_z) : 16'(i_beat.vec_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    // dividend carries the half-divisor for round to nearest
    always_ff @(posedge i_clk) begin
        r_beat[0] <= i_beat;
        r_len[0]  <= i_len;
        for (int c = 0; c < 3; c++) begin
            r_rem[0][c] <= (DIV_W'(w_mag[c]) << (FRAC_BITS + NORM_GUARD))
                           + DIV_W'(i_len >> 1);
            r_quo[0][c] <= '0;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int QBIT = QUO_W - 1 - j;
        logic [DIV_W-1:0] w_dvs;
        assign w_dvs = DIV_W'(r_len[j]) << QBIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_beat[j+1] <= r_beat[j];
            r_len[j+1]  <= r_len[j];
            for (int c = 0; c < 3; c++) begin
                if (r_rem[j][c] >= w_dvs) begin
                    r_rem[j+1][c] <= r_rem[j][c] - w_dvs;
                    r_quo[j+1][c] <= r_quo[j][c] | (QUO_W'(1) << QBIT);
                end else begin
                    r_rem[j+1][c] <= r_rem[j][c];
                    r_quo[j+1][c] <= r_quo[j][c];
                end
            end
        end
    end

    // restore signs
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_n[c] = signed'({1'b0, r_quo[QUO_W][c]});
        end
        o_unit.nx = r_beat[QUO_W].vec_x[15] ? -w_n[0] : w_n[0];
        o_unit.ny = r_beat[QUO_W].vec_y[15] ? -w_n[1] : w_n[1];
        o_unit.nz = r_beat[QUO_W].vec_z[15] ? -w_n[2] : w_n[2];
    end

    assign o_valid = r_v[QUO_W];
    assign o_beat  = r_beat[QUO_W];

endmodule

[design/qvr_rotate.sv]
// Two Hamilton products q * (n * conj(q)) in four stages, with rounding and clamping.
`timescale 1ns / 1ps
module qvr_rotate
    import qvr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_beat   i_beat,
    input  t_unit      i_unit,
    output logic       o_valid,
    output t_out_beat  o_result
);

    localparam logic signed [S1_W-1:0] RND1  = S1_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [S2_W-1:0] RND2  = S2_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [R_W-1:0]  R_MAX = R_W'((64'd1 << (COMP_WIDTH - 1)) - 1);
    localparam logic signed [R_W-1:0]  R_MIN = -R_MAX - R_W'(1);

    logic                   r_va, r_vb, r_vc, r_vd;
    t_in_beat               r_beat_a, r_beat_b, r_beat_c;
    logic signed [P1_W-1:0] r_p1 [0:11];
    logic signed [T_W-1:0]  r_t  [0:3];
    logic signed [P2_W-1:0] r_p2 [0:11];
    logic signed [S1_W-1:0] n_s1 [0:3];
    logic signed [S2_W-1:0] n_s2 [0:2];
    logic signed [R_W-1:0]  w_r  [0:2];
    logic signed [COMP_WIDTH-1:0] w_c [0:2];
    logic                   w_sat [0:2];
    logic                   w_zero;
    t_out_beat              r_result;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // stage A: products of n and q
    always_ff @(posedge i_clk) begin
        r_beat_a <= i_beat;
        r_p1[0]  <= i_unit.nx * i_beat.quat_w;
        r_p1[1]  <= i_unit.ny * i_beat.quat_z;
        r_p1[2]  <= i_unit.nz * i_beat.quat_y;
        r_p1[3]  <= i_unit.ny * i_beat.quat_w;
        r_p1[4]  <= i_unit.nz * i_beat.quat_x;
        r_p1[5]  <= i_unit.nx * i_beat.quat_z;
        r_p1[6]  <= i_unit.nz * i_beat.quat_w;
        r_p1[7]  <= i_unit.nx * i_beat.quat_y;
        r_p1[8]  <= i_unit.ny * i_beat.quat_x;
        r_p1[9]  <= i_unit.nx * i_beat.quat_x;
        r_p1[10] <= i_unit.ny * i_beat.quat_y;
        r_p1[11] <= i_unit.nz * i_beat.quat_z;
    end

    // stage B: t = n * conj(q), rounded half up, kept wide
    always_comb begin
        n_s1[0] = S1_W'(r_p1[0]) - S1_W'(r_p1[1]) + S1_W'(r_p1[2]) + RND1;
        n_s1[1] = S1_W'(r_p1[3]) - S1_W'(r_p1[4]) + S1_W'(r_p1[5]) + RND1;
        n_s1[2] = S1_W'(r_p1[6]) - S1_W'(r_p1[7]) + S1_W'(r_p1[8]) + RND1;
        n_s1[3] = S1_W'(r_p1[9]) + S1_W'(r_p1[10]) + S1_W'(r_p1[11]) + RND1;
    end

    always_ff @(posedge i_clk) begin
        r_beat_b <= r_beat_a;
        for (int k = 0; k < 4; k++) begin
            r_t[k] <= n_s1[k][S1_W-1:FRAC_BITS];
        end
    end

    // stage C: products of q and t (t order: x, y, z, w)
    always_ff @(posedge i_clk) begin
        r_beat_c <= r_beat_b;
        r_p2[0]  <= r_beat_b.quat_w * r_t[0];
        r_p2[1]  <= r_beat_b.quat_x * r_t[3];
        r_p2[2]  <= r_beat_b.quat_y * r_t[2];
        r_p2[3]  <= r_beat_b.quat_z * r_t[1];
        r_p2[4]  <= r_beat_b.quat_w * r_t[1];
        r_p2[5]  <= r_beat_b.quat_y * r_t[3];
        r_p2[6]  <= r_beat_b.quat_z * r_t[0];
        r_p2[7]  <= r_beat_b.quat_x * r_t[2];
        r_p2[8]  <= r_beat_b.quat_w * r_t[2];
        r_p2[9]  <= r_beat_b.quat_z * r_t[3];
        r_p2[10] <= r_beat_b.quat_x * r_t[1];
        r_p2[11] <= r_beat_b.quat_y * r_t[0];
    end

    // stage D: sum, round, clamp; zero vector forces a clean result
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2[c] = S2_W'(r_p2[4*c]) + S2_W'(r_p2[4*c+1]) + S2_W'(r_p2[4*c+2])
                      - S2_W'(r_p2[4*c+3]) + RND2;
            w_r[c]  = n_s2[c][S2_W-1:FRAC_BITS];
            if (w_r[c] > R_MAX) begin
                w_c[c]   = R_MAX[COMP_WIDTH-1:0];
                w_sat[c] = 1'b1;
            end else if (w_r[c] < R_MIN) begin
                w_c[c]   = R_MIN[COMP_WIDTH-1:0];
                w_sat[c] = 1'b1;
            end else begin
                w_c[c]   = w_r[c][COMP_WIDTH-1:0];
                w_sat[c] = 1'b0;
            end
        end
        w_zero = (r_beat_c.vec_x == '0) && (r_beat_c.vec_y == '0)
                 && (r_beat_c.vec_z == '0);
    end

    always_ff @(posedge i_clk) begin
        r_result.zero_vector <= w_zero;
        r_result.rot_x       <= w_zero ? '0 : w_c[0];
        r_result.rot_y       <= w_zero ? '0 : w_c[1];
        r_result.rot_z       <= w_zero ? '0 : w_c[2];
        r_result.saturated   <= !w_zero && (w_sat[0] || w_sat[1] || w_sat[2]);
    end

    assign o_valid  = r_vd;
    assign o_result = r_result;

endmodule

[design/quaternion_vector_rotate.sv]
// Top level: normalize a vector and rotate it by a quaternion, one beat per cycle.
`timescale 1ns / 1ps
// Takes one beat on every cycle that start is high; busy is always low. Each
// beat's result appears on o_result for exactly one cycle, marked by o_done,
// in input order, after the 33-stage square-root pipeline (sum of squares
// plus one root bit per stage), the 16-stage unit-length divider (one
// quotient bit per stage) and the four-stage Hamilton product. The result
// is not held: the receiver must take it on the cycle o_done is high.
// Components are Q1.14, saturated with a flag; a zero vector gives zeros
// with zero_vector set.
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_beat   i_item,
    output logic       o_done,
    output t_out_beat  o_result
);

    logic              w_acc;
    logic              w_sq_valid;
    t_in_beat          w_sq_beat;
    logic [LEN_W-1:0]  w_len;
    logic              w_dv_valid;
    t_in_beat          w_dv_beat;
    t_unit             w_unit;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    qvr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_beat  (i_item),
        .o_valid (w_sq_valid),
        .o_beat  (w_sq_beat),
        .o_len   (w_len)
    );

    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_beat  (w_sq_beat),
        .i_len   (w_len),
        .o_valid (w_dv_valid),
        .o_beat  (w_dv_beat),
        .o_unit  (w_unit)
    );

    qvr_rotate u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_dv_valid),
        .i_beat   (w_dv_beat),
        .i_unit   (w_unit),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    // zero vector gives a clean zero result
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.zero_vector |-> o_result.rot_x == '0
            && o_result.rot_y == '0 && o_result.rot_z == '0 && !o_result.saturated)
        else $error("zero vector result not clean");

    // a clamped result sits on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.saturated |->
            o_result.rot_x == {1'b0, {(COMP_WIDTH-1){1'b1}}}
            || o_result.rot_x == {1'b1, {(COMP_WIDTH-1){1'b0}}}
            || o_result.rot_y == {1'b0, {(COMP_WIDTH-1){1'b1}}}
            || o_result.rot_y == {1'b1, {(COMP_WIDTH-1){1'b0}}}
            || o_result.rot_z == {1'b0, {(COMP_WIDTH-1){1'b1}}}
            || o_result.rot_z == {1'b1, {(COMP_WIDTH-1){1'b0}}})
        else $error("saturated flag without clamped component");

    // unit-length components never exceed one in magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_valid && !(w_dv_beat.vec_x == '0 && w_dv_beat.vec_y == '0
            && w_dv_beat.vec_z == '0) |->
            w_unit.nx <= 16'sd16384 && w_unit.nx >= -16'sd16384
            && w_unit.ny <= 16'sd16384 && w_unit.ny >= -16'sd16384
            && w_unit.nz <= 16'sd16384 && w_unit.nz >= -16'sd16384)
        else $error("normalized component out of range");

endmodule

[tb/testbench.sv]
// Testbench for the quaternion rotator: directed table plus random beats, checked by a predictor.
`timescale 1ns / 1ps
module testbench;
    import qvr_pkg::*;

    localparam int LATENCY   = 53;
    localparam int N_RANDOM  = 500;
    localparam int MAX_CYCLE = 200000;
    localparam int N_DIR     = 16;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_beat  i_item = '0;
    logic      o_done;
    t_out_beat o_result;

    quaternion_vector_rotate uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_out_beat rotation_queue[$];
    int        mismatches = 0;
    int        cycles = 0;

    // bitwise square root of a 64-bit radicand, 32 rounds
    function automatic longint unsigned sqrt64(longint unsigned x);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= root + bitv) begin
                x    = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // floor((x + half) / 2^FRAC_BITS)
    function automatic longint round_q(longint x);
        return (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint unit_comp(longint v, longint unsigned len);
        longint unsigned mag, q;
        mag = (v < 0) ? -v : v;
        q   = ((mag << (FRAC_BITS + NORM_GUARD)) + (len >> 1)) / len;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [COMP_WIDTH-1:0] clamp_comp(longint x, ref logic sat);
        longint hi, lo;
        hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin x = hi; sat = 1'b1; end
        if (x < lo) begin x = lo; sat = 1'b1; end
        return x[COMP_WIDTH-1:0];
    endfunction

    function automatic t_out_beat rotate_unit(t_in_beat b);
        t_out_beat r;
        longint qx, qy, qz, qw, vx, vy, vz, nx, ny, nz, tx, ty, tz, tw;
        longint unsigned s, len;
        logic sat;
        qx = b.quat_x; qy = b.quat_y; qz = b.quat_z; qw = b.quat_w;
        vx = b.vec_x;  vy = b.vec_y;  vz = b.vec_z;
        r = '0;
        sat = 1'b0;
        if (vx == 0 && vy == 0 && vz == 0) begin
            r.zero_vector = 1'b1;
            return r;
        end
        s   = vx * vx + vy * vy + vz * vz;
        len = sqrt64(s << (2 * NORM_GUARD));
        nx = unit_comp(vx, len);
        ny = unit_comp(vy, len);
        nz = unit_comp(vz, len);
        tx = round_q(nx * qw - ny * qz + nz * qy);
        ty = round_q(ny * qw - nz * qx + nx * qz);
        tz = round_q(nz * qw - nx * qy + ny * qx);
        tw = round_q(nx * qx + ny * qy + nz * qz);
        r.rot_x = clamp_comp(round_q(qw * tx + qx * tw + qy * tz - qz * ty), sat);
        r.rot_y = clamp_comp(round_q(qw * ty + qy * tw + qz * tx - qx * tz), sat);
        r.rot_z = clamp_comp(round_q(qw * tz + qz * tw + qx * ty - qy * tx), sat);
        r.saturated = sat;
        return r;
    endfunction

    // directed table: quat x,y,z,w, vec x,y,z; has_exp marks typed-in results
    typedef struct {
        t_in_beat  beat;
        bit        has_exp;
        t_out_beat expv;
    } t_row;
    t_row dir_rows[N_DIR];

    initial begin
        // zero vector with identity and with extreme quaternion
        dir_rows[0]  = '{'{0, 0, 0, 16384, 0, 0, 0}, 1, '{0, 0, 0, 1, 0}};
        dir_rows[1]  = '{'{-32768, -32768, -32768, -32768, 0, 0, 0}, 1, '{0, 0, 0, 1, 0}};
        // identity rotation of axis vectors
        dir_rows[2]  = '{'{0, 0, 0, 16384, 5, 0, 0}, 1, '{16384, 0, 0, 0, 0}};
        dir_rows[3]  = '{'{0, 0, 0, 16384, 0, -32768, 0}, 1, '{0, -16384, 0, 0, 0}};
        dir_rows[4]  = '{'{0, 0, 0, 16384, 0, 0, 32767}, 1, '{0, 0, 16384, 0, 0}};
        // extremes and non-unit quaternions: predictor
        dir_rows[5]  = '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767}, 0, '0};
        dir_rows[6]  = '{'{-32768, 32767, -32768, 32767, -32768, -32768, -32768}, 0, '0};
        dir_rows[7]  = '{'{11585, 0, 0, 11585, 0, 1, 0}, 0, '0};
        dir_rows[8]  = '{'{0, 11585, 0, 11585, 1, 0, 0}, 0, '0};
        dir_rows[9]  = '{'{0, 0, 16384, 0, 3, 4, 0}, 0, '0};
        dir_rows[10] = '{'{8192, 8192, 8192, 8192, -1, -1, -1}, 0, '0};
        dir_rows[11] = '{'{0, 0, 0, 0, 100, 200, 300}, 0, '0};
        dir_rows[12] = '{'{-1, -1, -1, -1, 32767, -32768, 1}, 0, '0};
        dir_rows[13] = '{'{16384, 16384, 16384, 16384, 1, 1, 1}, 0, '0};
        dir_rows[14] = '{'{0, 0, 0, -32768, -32768, 0, 0}, 0, '0};
        dir_rows[15] = '{'{21000, -9000, 4000, -15000, 7, -13, 2}, 0, '0};
    end

    function automatic t_in_beat random_beat(int mode);
        t_in_beat b;
        b = '0;
        b.quat_x = 16'($urandom); b.quat_y = 16'($urandom);
        b.quat_z = 16'($urandom); b.quat_w = 16'($urandom);
        b.vec_x = 16'($urandom); b.vec_y = 16'($urandom); b.vec_z = 16'($urandom);
        if (mode < 50) begin
            // near-unit quaternions mostly
            b.quat_x = 16'($signed($urandom_range(0, 16384)) - 8192);
            b.quat_y = 16'($signed($urandom_range(0, 16384)) - 8192);
            b.quat_z = 16'($signed($urandom_range(0, 16384)) - 8192);
            b.quat_w = 16'($signed($urandom_range(0, 16384)) - 8192);
        end
        if (mode % 7 == 0) begin
            b.vec_x = 16'($signed($urandom_range(0, 6)) - 3);
            b.vec_y = 16'($signed($urandom_range(0, 6)) - 3);
            b.vec_z = 16'($signed($urandom_range(0, 6)) - 3);
        end
        return b;
    endfunction

    // sender: accepts at a rising edge with start high and busy low
    task automatic send_beat(t_in_beat b, bit idle_ok);
        while (idle_ok && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        rotation_queue.push_back(rotate_unit(b));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (rotation_queue.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rotation_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_result);
            end else begin
                t_out_beat e;
                e = rotation_queue.pop_front();
                if (o_result !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, o_result);
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIR; i++) begin
            send_beat(dir_rows[i].beat, 1'b1);
            if (dir_rows[i].has_exp && rotation_queue[$] !== dir_rows[i].expv) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: typed %p predicted %p", i,
                             dir_rows[i].expv, rotation_queue[$]);
            end
        end
        // hold off until the pipeline is empty
        wait_drained();
        for (int i = 0; i < N_RANDOM; i++) begin
            // beats 150 to 299 form a back-to-back stretch with no idle gaps
            send_beat(random_beat($urandom_range(0, 99)), !(i >= 150 && i < 300));
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
